FILE: rtl/pstt_pkg.sv
// Shared types and constants for the PID steering block with twiddle tuning.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package pstt_pkg;

  // register file
  localparam int unsigned REG_W     = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_GAINS = 3;

  // fixed field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned UTIL_W   = 32;
  localparam int unsigned STEER_W  = 48;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned FACTOR_W = 17;
  localparam int unsigned FRAC_W   = 16;
  // products and partial sums are limited to +-2^LIM_EXP
  localparam int unsigned LIM_EXP  = 61;
  localparam int unsigned LIM_W    = LIM_EXP + 2;

  // step scaling, Q1.16
  localparam logic [FACTOR_W-1:0] STEP_UP   = 17'd72090;
  localparam logic [FACTOR_W-1:0] STEP_DOWN = 17'd58982;

  // gain selection
  localparam logic [1:0] IDX_P     = 2'd0;
  localparam logic [1:0] IDX_I     = 2'd1;
  localparam logic [1:0] IDX_D     = 2'd2;
  localparam logic [1:0] TUNE_LAST = IDX_D;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_END_TRIAL = 2'd1,
    CMD_LOAD      = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P = 3'd0,
    CFG_GAIN_I = 3'd1,
    CFG_GAIN_D = 3'd2,
    CFG_STEP_P = 3'd3,
    CFG_STEP_I = 3'd4,
    CFG_STEP_D = 3'd5
  } cfg_idx_e;

  // twiddle phase, one-hot
  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_PLUS  = 3'b010,
    PH_MINUS = 3'b100
  } phase_e;

  typedef struct packed {
    logic [NUM_GAINS-1:0][REG_W-1:0] gain;
    logic [NUM_GAINS-1:0][REG_W-1:0] step;
  } cfg_regs_t;

  typedef struct packed {
    logic       taken;
    logic       improved;
    logic [1:0] index;
    logic [1:0] phase;
  } tune_status_t;

  function automatic logic [1:0] phase_code(input phase_e ph);
    logic [1:0] code;
    unique case (ph)
      PH_START: code = 2'd0;
      PH_PLUS:  code = 2'd1;
      PH_MINUS: code = 2'd2;
      default:  code = 2'd0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pstt_in_if.sv
// Input channel: sample, end-of-trial and load requests.
// Depends on pstt_pkg for the fixed field widths.
`default_nettype none

interface pstt_in_if #(
  parameter int unsigned ERROR_WIDTH = 16
);
  logic                              valid;
  logic                              ready;
  logic [pstt_pkg::CMD_W-1:0]        command;
  logic signed [ERROR_WIDTH-1:0]     cross_error;
  logic signed [pstt_pkg::UTIL_W-1:0] trial_utility;

  modport source (output valid, command, cross_error, trial_utility, input ready);
  modport sink   (input valid, command, cross_error, trial_utility, output ready);
endinterface

`default_nettype wire

FILE: rtl/pstt_out_if.sv
// Output channel: steering value and tuner status, one per request.
// Depends on pstt_pkg for the fixed field widths.
`default_nettype none

interface pstt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pstt_pkg::STEER_W-1:0] steering;
  logic                                trial_taken;
  logic                                improved;
  logic [1:0]                          tuned_index;
  logic [1:0]                          tune_phase;

  modport source (output valid, steering, trial_taken, improved, tuned_index, tune_phase,
                  input ready);
  modport sink   (input valid, steering, trial_taken, improved, tuned_index, tune_phase,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/pstt_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on pstt_pkg for the index and data widths.
`default_nettype none

interface pstt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pstt_pkg::CFG_IDX_W-1:0]    index;
  logic [pstt_pkg::REG_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/pid_steering_with_twiddle_tuner_unit.sv
// PID steering controller with twiddle gain tuning: top level.
// Depends on pstt_pkg, the channel interfaces, pstt_cfg_regs, pstt_core, pstt_sum.
//
// Usage:
//  - in_i carries one request per handshake: a sample (cross_error), an end of
//    trial (trial_utility) or a load of the configured gains and steps.
//  - out_o returns exactly one result per request, in order: steering for a
//    sample (zero otherwise) plus the tuner status after the request.
//  - cfg_i writes the six initial gain/step registers; write only while idle.
//    Gains and steps take effect on the next load request.
//  - A result passes three registered stages before it is on out_o: input
//    register, state update with the three products, sum and saturate.
//  - One request per cycle while out_o accepts; the controller state is read
//    and written in the single state-update stage, so requests follow back to back.
//  - When out_o stalls, each of the three stages still fills, so three
//    requests are held before in_i.ready drops.
//  - Reset clears all gains, steps and the trial and tuner state; there is no
//    clearing pass, the block accepts requests as soon as reset is released.
`default_nettype none

module pid_steering_with_twiddle_tuner_unit #(
  parameter int unsigned ERROR_WIDTH    = 16,
  parameter int unsigned INTEGRAL_WIDTH = 32,
  parameter int unsigned GAIN_WIDTH     = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pstt_in_if.sink     in_i,
  pstt_out_if.source  out_o,
  pstt_cfg_if.sink    cfg_i
);

  localparam int unsigned EW = ERROR_WIDTH;
  localparam int unsigned IW = INTEGRAL_WIDTH;
  localparam int unsigned GW = GAIN_WIDTH;

  pstt_pkg::cfg_regs_t cfg_regs;

  // stage valids
  logic a_v_q, b_v_q, c_v_q;
  logic a_rdy, b_rdy, c_rdy;
  logic b_adv, c_adv;

  // input register
  logic [pstt_pkg::CMD_W-1:0]         cmd_q;
  logic signed [EW-1:0]               err_q;
  logic signed [pstt_pkg::UTIL_W-1:0] util_q;

  logic signed [GW+EW-1:0]         prod_p;
  logic signed [GW+EW:0]           prod_d;
  logic signed [GW+IW-1:0]         prod_i;
  pstt_pkg::tune_status_t          status_b, status_c;
  logic signed [pstt_pkg::STEER_W-1:0] steering;

  assign c_rdy = !c_v_q || out_o.ready;
  assign b_rdy = !b_v_q || c_rdy;
  assign a_rdy = !a_v_q || b_rdy;
  assign b_adv = a_v_q && b_rdy;
  assign c_adv = b_v_q && c_rdy;

  assign in_i.ready = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= in_i.valid;
      if (b_rdy) b_v_q <= a_v_q;
      if (c_rdy) c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && a_rdy) begin
      cmd_q  <= in_i.command;
      err_q  <= in_i.cross_error;
      util_q <= in_i.trial_utility;
    end
  end

  pstt_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (cfg_regs)
  );

  pstt_core #(
    .ERROR_WIDTH    (ERROR_WIDTH),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH),
    .GAIN_WIDTH     (GAIN_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (b_adv),
    .cmd_i    (cmd_q),
    .err_i    (err_q),
    .util_i   (util_q),
    .cfg_i    (cfg_regs),
    .prod_p_o (prod_p),
    .prod_d_o (prod_d),
    .prod_i_o (prod_i),
    .status_o (status_b)
  );

  pstt_sum #(
    .ERROR_WIDTH    (ERROR_WIDTH),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH),
    .GAIN_WIDTH     (GAIN_WIDTH)
  ) u_sum (
    .clk_i      (clk_i),
    .adv_i      (c_adv),
    .prod_p_i   (prod_p),
    .prod_d_i   (prod_d),
    .prod_i_i   (prod_i),
    .status_i   (status_b),
    .steering_o (steering),
    .status_o   (status_c)
  );

  assign out_o.valid       = c_v_q;
  assign out_o.steering    = steering;
  assign out_o.trial_taken = status_c.taken;
  assign out_o.improved    = status_c.improved;
  assign out_o.tuned_index = status_c.index;
  assign out_o.tune_phase  = status_c.phase;

  // checks
  a_b_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_adv |=> b_v_q)
    else $error("request lost between input register and state stage");

  a_improved_taken : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.improved |-> out_o.trial_taken)
    else $error("improvement flagged without a twiddle step");

  a_taken_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.trial_taken |->
      (out_o.tune_phase == pstt_pkg::phase_code(pstt_pkg::PH_PLUS)) ||
      (out_o.tune_phase == pstt_pkg::phase_code(pstt_pkg::PH_MINUS)))
    else $error("twiddle step left the tuner in its start phase");

  a_taken_no_steer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.trial_taken |-> out_o.steering == '0)
    else $error("steering driven on an end-of-trial result");

  a_index_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.tuned_index <= pstt_pkg::TUNE_LAST)
    else $error("tuned gain index out of range");

endmodule

`default_nettype wire

FILE: rtl/pstt_cfg_regs.sv
// Initial gain and step registers, written through the configuration channel.
// Depends on pstt_pkg and pstt_cfg_if.
`default_nettype none

module pstt_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  pstt_cfg_if.sink            cfg_i,
  output pstt_pkg::cfg_regs_t regs_o
);

  pstt_pkg::cfg_regs_t regs_q, regs_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        pstt_pkg::CFG_GAIN_P: regs_d.gain[0] = cfg_i.data;
        pstt_pkg::CFG_GAIN_I: regs_d.gain[1] = cfg_i.data;
        pstt_pkg::CFG_GAIN_D: regs_d.gain[2] = cfg_i.data;
        pstt_pkg::CFG_STEP_P: regs_d.step[0] = cfg_i.data;
        pstt_pkg::CFG_STEP_I: regs_d.step[1] = cfg_i.data;
        pstt_pkg::CFG_STEP_D: regs_d.step[2] = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign regs_o = regs_q;

endmodule

`default_nettype wire

FILE: rtl/pstt_core.sv
// Controller state, twiddle step and the three PID products (registered).
// Depends on pstt_pkg.
`default_nettype none

module pstt_core #(
  parameter int unsigned ERROR_WIDTH    = 16,
  parameter int unsigned INTEGRAL_WIDTH = 32,
  parameter int unsigned GAIN_WIDTH     = 24
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         adv_i,
  input  logic [pstt_pkg::CMD_W-1:0]                   cmd_i,
  input  logic signed [ERROR_WIDTH-1:0]                err_i,
  input  logic signed [pstt_pkg::UTIL_W-1:0]           util_i,
  input  pstt_pkg::cfg_regs_t                          cfg_i,
  output logic signed [GAIN_WIDTH+ERROR_WIDTH-1:0]     prod_p_o,
  output logic signed [GAIN_WIDTH+ERROR_WIDTH:0]       prod_d_o,
  output logic signed [GAIN_WIDTH+INTEGRAL_WIDTH-1:0]  prod_i_o,
  output pstt_pkg::tune_status_t                       status_o
);

  localparam int unsigned EW     = ERROR_WIDTH;
  localparam int unsigned IW     = INTEGRAL_WIDTH;
  localparam int unsigned GW     = GAIN_WIDTH;
  localparam int unsigned NG     = pstt_pkg::NUM_GAINS;
  localparam int unsigned SG_W   = (pstt_pkg::REG_W > GW + 2) ? pstt_pkg::REG_W : GW + 2;
  localparam int unsigned ISUM_W = ((IW > EW) ? IW : EW) + 1;
  localparam int unsigned PE_W   = GW + EW;
  localparam int unsigned PD_W   = GW + EW + 1;
  localparam int unsigned PI_W   = GW + IW;
  localparam int unsigned SP_W   = GW + pstt_pkg::FACTOR_W;

  localparam logic signed [SG_W-1:0]   G_HI = SG_W'({(GW-1){1'b1}});
  localparam logic signed [SG_W-1:0]   G_LO = ~G_HI;
  localparam logic signed [ISUM_W-1:0] I_HI = ISUM_W'({(IW-1){1'b1}});
  localparam logic signed [ISUM_W-1:0] I_LO = ~I_HI;
  localparam logic [pstt_pkg::CNT_W-1:0] CNT_MAX = '1;
  localparam logic [SP_W-1:0] ROUND_HALF = SP_W'(1) << (pstt_pkg::FRAC_W - 1);

  localparam int unsigned IDX_P_I = 32'(pstt_pkg::IDX_P);
  localparam int unsigned IDX_I_I = 32'(pstt_pkg::IDX_I);
  localparam int unsigned IDX_D_I = 32'(pstt_pkg::IDX_D);

  function automatic logic signed [GW-1:0] sat_g(input logic signed [SG_W-1:0] x);
    logic signed [GW-1:0] r;
    if (x > G_HI) begin
      r = G_HI[GW-1:0];
    end else if (x < G_LO) begin
      r = G_LO[GW-1:0];
    end else begin
      r = x[GW-1:0];
    end
    return r;
  endfunction

  // state
  logic signed [GW-1:0]               gain_q [NG];
  logic signed [GW-1:0]               gain_d [NG];
  logic signed [GW-1:0]               step_q [NG];
  logic signed [GW-1:0]               step_d [NG];
  logic signed [IW-1:0]               integ_q, integ_d;
  logic signed [EW-1:0]               prev_q, prev_d;
  logic                               nop_q, nop_d;
  logic [pstt_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [pstt_pkg::UTIL_W-1:0] best_q, best_d;
  logic                               first_q, first_d;
  logic [1:0]                         idx_q, idx_d;
  pstt_pkg::phase_e                   ph_q, ph_d;

  // datapath
  logic signed [ISUM_W-1:0]           integ_sum;
  logic signed [IW-1:0]               integ_new;
  logic signed [EW:0]                 de;
  logic                               is_sample;
  logic                               taken;
  logic                               better;
  logic signed [pstt_pkg::UTIL_W-1:0] best_eff;
  logic [1:0]                         nidx;
  logic signed [GW-1:0]               g_k, s_k, g_n, s_n;
  logic signed [GW-1:0]               g_plus, g_minus, g_n_plus, s_scaled;
  logic [pstt_pkg::FACTOR_W-1:0]      factor;
  logic [GW-1:0]                      s_mag;
  logic [SP_W-1:0]                    s_prod;
  logic [GW:0]                        s_rnd;
  logic signed [SG_W-1:0]             s_val;

  logic signed [PE_W-1:0] prod_p_q, prod_p_d;
  logic signed [PD_W-1:0] prod_d_q, prod_d_d;
  logic signed [PI_W-1:0] prod_i_q, prod_i_d;
  pstt_pkg::tune_status_t status_q, status_d;

  // sample path
  always_comb begin
    is_sample = (cmd_i == pstt_pkg::CMD_SAMPLE);
    integ_sum = ISUM_W'(integ_q) + ISUM_W'(err_i);
    if (integ_sum > I_HI) begin
      integ_new = I_HI[IW-1:0];
    end else if (integ_sum < I_LO) begin
      integ_new = I_LO[IW-1:0];
    end else begin
      integ_new = integ_sum[IW-1:0];
    end
    de = nop_q ? '0 : ((EW+1)'(err_i) - (EW+1)'(prev_q));
    prod_p_d = is_sample ? (PE_W'(gain_q[IDX_P_I]) * PE_W'(err_i)) : '0;
    prod_d_d = is_sample ? (PD_W'(gain_q[IDX_D_I]) * PD_W'(de)) : '0;
    prod_i_d = is_sample ? (PI_W'(gain_q[IDX_I_I]) * PI_W'(integ_new)) : '0;
  end

  // twiddle path
  always_comb begin
    taken    = (cmd_i == pstt_pkg::CMD_END_TRIAL) && (cnt_q > pstt_pkg::CNT_W'(1));
    best_eff = first_q ? util_i : best_q;
    better   = taken && (ph_q != pstt_pkg::PH_START) && (util_i > best_eff);
    nidx     = (idx_q >= pstt_pkg::TUNE_LAST) ? pstt_pkg::IDX_P : idx_q + 2'd1;

    g_k = gain_q[0];
    s_k = step_q[0];
    g_n = gain_q[0];
    s_n = step_q[0];
    for (int i = 1; i < NG; i++) begin
      if (idx_q == 2'(i)) begin
        g_k = gain_q[i];
        s_k = step_q[i];
      end
      if (nidx == 2'(i)) begin
        g_n = gain_q[i];
        s_n = step_q[i];
      end
    end

    g_plus   = sat_g(SG_W'(g_k) + SG_W'(s_k));
    g_minus  = sat_g(SG_W'(g_k) - (SG_W'(s_k) <<< 1));
    g_n_plus = sat_g(SG_W'(g_n) + SG_W'(s_n));

    // step * 1.1 or * 0.9 on the magnitude, round half away from zero
    factor   = better ? pstt_pkg::STEP_UP : pstt_pkg::STEP_DOWN;
    s_mag    = s_k[GW-1] ? GW'(-s_k) : GW'(s_k);
    s_prod   = SP_W'(s_mag) * SP_W'(factor) + ROUND_HALF;
    s_rnd    = s_prod[SP_W-1:pstt_pkg::FRAC_W];
    s_val    = s_k[GW-1] ? -signed'(SG_W'(s_rnd)) : signed'(SG_W'(s_rnd));
    s_scaled = sat_g(s_val);
  end

  always_comb begin
    gain_d  = gain_q;
    step_d  = step_q;
    integ_d = integ_q;
    prev_d  = prev_q;
    nop_d   = nop_q;
    cnt_d   = cnt_q;
    best_d  = best_q;
    first_d = first_q;
    idx_d   = idx_q;
    ph_d    = ph_q;

    unique case (cmd_i)
      pstt_pkg::CMD_SAMPLE: begin
        integ_d = integ_new;
        prev_d  = err_i;
        nop_d   = 1'b0;
        cnt_d   = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
      end
      pstt_pkg::CMD_END_TRIAL: begin
        if (taken) begin
          first_d = 1'b0;
          if (first_q || better) begin
            best_d = util_i;
          end
          integ_d = '0;
          prev_d  = '0;
          nop_d   = 1'b1;
          cnt_d   = '0;
          for (int i = 0; i < NG; i++) begin
            unique case (ph_q)
              pstt_pkg::PH_START: begin
                if (idx_q == 2'(i)) gain_d[i] = g_plus;
              end
              pstt_pkg::PH_PLUS: begin
                if (better) begin
                  if (idx_q == 2'(i)) step_d[i] = s_scaled;
                  if (nidx == 2'(i))  gain_d[i] = g_n_plus;
                end else begin
                  if (idx_q == 2'(i)) gain_d[i] = g_minus;
                end
              end
              pstt_pkg::PH_MINUS: begin
                if (idx_q == 2'(i)) begin
                  step_d[i] = s_scaled;
                  if (!better) gain_d[i] = g_plus;
                end
                if (nidx == 2'(i)) gain_d[i] = g_n_plus;
              end
              default: ;
            endcase
          end
          // a finished gain moves on and the next one is nudged straight away
          if (ph_q == pstt_pkg::PH_START) begin
            ph_d = pstt_pkg::PH_PLUS;
          end else if (ph_q == pstt_pkg::PH_PLUS && !better) begin
            ph_d = pstt_pkg::PH_MINUS;
          end else begin
            idx_d = nidx;
            ph_d  = pstt_pkg::PH_PLUS;
          end
        end
      end
      pstt_pkg::CMD_LOAD: begin
        for (int i = 0; i < NG; i++) begin
          gain_d[i] = sat_g(SG_W'(signed'(cfg_i.gain[i])));
          step_d[i] = sat_g(SG_W'(signed'(cfg_i.step[i])));
        end
      end
      default: ;
    endcase

    status_d.taken    = taken;
    status_d.improved = better;
    status_d.index    = idx_d;
    status_d.phase    = pstt_pkg::phase_code(ph_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NG; i++) begin
        gain_q[i] <= '0;
        step_q[i] <= '0;
      end
      integ_q <= '0;
      prev_q  <= '0;
      nop_q   <= 1'b1;
      cnt_q   <= '0;
      best_q  <= '0;
      first_q <= 1'b1;
      idx_q   <= pstt_pkg::IDX_P;
      ph_q    <= pstt_pkg::PH_START;
    end else if (adv_i) begin
      gain_q  <= gain_d;
      step_q  <= step_d;
      integ_q <= integ_d;
      prev_q  <= prev_d;
      nop_q   <= nop_d;
      cnt_q   <= cnt_d;
      best_q  <= best_d;
      first_q <= first_d;
      idx_q   <= idx_d;
      ph_q    <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_p_q <= prod_p_d;
      prod_d_q <= prod_d_d;
      prod_i_q <= prod_i_d;
      status_q <= status_d;
    end
  end

  assign prod_p_o = prod_p_q;
  assign prod_d_o = prod_d_q;
  assign prod_i_o = prod_i_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

FILE: rtl/pstt_sum.sv
// Limits and sums the PID products, negates and saturates to the steering
// width; holds the output register. Depends on pstt_pkg.
`default_nettype none

module pstt_sum #(
  parameter int unsigned ERROR_WIDTH    = 16,
  parameter int unsigned INTEGRAL_WIDTH = 32,
  parameter int unsigned GAIN_WIDTH     = 24
) (
  input  logic                                         clk_i,
  input  logic                                         adv_i,
  input  logic signed [GAIN_WIDTH+ERROR_WIDTH-1:0]     prod_p_i,
  input  logic signed [GAIN_WIDTH+ERROR_WIDTH:0]       prod_d_i,
  input  logic signed [GAIN_WIDTH+INTEGRAL_WIDTH-1:0]  prod_i_i,
  input  pstt_pkg::tune_status_t                       status_i,
  output logic signed [pstt_pkg::STEER_W-1:0]          steering_o,
  output pstt_pkg::tune_status_t                       status_o
);

  localparam int unsigned PI_W  = GAIN_WIDTH + INTEGRAL_WIDTH;
  localparam int unsigned PD_W  = GAIN_WIDTH + ERROR_WIDTH + 1;
  localparam int unsigned PM_W  = (PI_W > PD_W) ? PI_W : PD_W;
  localparam int unsigned X_W   = (PM_W > 64) ? PM_W : 64;
  localparam int unsigned LIM_W = pstt_pkg::LIM_W;
  localparam int unsigned SW    = pstt_pkg::STEER_W;

  localparam logic signed [X_W-1:0] LIM      = X_W'(1) << pstt_pkg::LIM_EXP;
  localparam logic signed [X_W-1:0] NLIM     = -LIM;
  localparam logic signed [X_W-1:0] STEER_HI = X_W'({(SW-1){1'b1}});
  localparam logic signed [X_W-1:0] STEER_LO = ~STEER_HI;

  function automatic logic signed [LIM_W-1:0] clamp(input logic signed [X_W-1:0] x);
    logic signed [LIM_W-1:0] r;
    if (x > LIM) begin
      r = LIM[LIM_W-1:0];
    end else if (x < NLIM) begin
      r = NLIM[LIM_W-1:0];
    end else begin
      r = x[LIM_W-1:0];
    end
    return r;
  endfunction

  logic signed [LIM_W-1:0] c_p, c_d, c_i, s1, s2;
  logic signed [X_W-1:0]   neg;
  logic signed [SW-1:0]    steer_d, steer_q;
  pstt_pkg::tune_status_t  status_q;

  always_comb begin
    c_p = clamp(X_W'(prod_p_i));
    c_d = clamp(X_W'(prod_d_i));
    c_i = clamp(X_W'(prod_i_i));
    s1  = clamp(X_W'(c_p) + X_W'(c_d));
    s2  = clamp(X_W'(s1) + X_W'(c_i));
    neg = -X_W'(s2);
    if (neg > STEER_HI) begin
      steer_d = STEER_HI[SW-1:0];
    end else if (neg < STEER_LO) begin
      steer_d = STEER_LO[SW-1:0];
    end else begin
      steer_d = neg[SW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      steer_q  <= steer_d;
      status_q <= status_i;
    end
  end

  assign steering_o = steer_q;
  assign status_o   = status_q;

endmodule

`default_nettype wire
